>>> src/rws_pkg.sv
`timescale 1ns / 1ps

package rws_pkg;

	// Sizes fixed by the field formats
	localparam int POINTS_DEFAULT = 64;
	localparam int VALUE_W        = 32;
	localparam int FRAC_W         = 17;
	localparam int IDX_W          = 6;
	localparam int CFG_IDX_W      = 1;

	// Fraction one in Q1.16 and the minimum window span in ranks
	localparam logic [FRAC_W-1:0] FRAC_ONE = FRAC_W'(65536);
	localparam int MIN_SPAN = 3;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MIN_FRACTION = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_FRACTION = 1'b1;

	typedef struct packed {
		logic signed [VALUE_W-1:0] feature_value;
		logic                      last_value;
	} item_t;

	typedef struct packed {
		logic [IDX_W-1:0] point_index;
		logic [IDX_W-1:0] point_rank;
		logic             active;
		logic             last_result;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CALC,
		ST_WIDEN,
		ST_FETCH,
		ST_LATCH,
		ST_SWEEP,
		ST_EMIT
	} state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load;    // store the incoming value
		logic finish;  // last value: latch point count, restart collection
		logic calc;    // window edges from fractions
		logic widen;   // enforce minimum span, rewind point index
		logic fetch;   // read value of current point
		logic latch;   // hold current value, start the compare sweep
		logic sweep;   // compare against each stored value
		logic emit;    // present result, advance point index
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic sweep_done;
		logic last_point;
	} status_t;

endpackage

>>> src/rws_ram.sv
`timescale 1ns / 1ps

module rws_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> src/rws_datapath.sv
`timescale 1ns / 1ps

module rws_datapath #(
	parameter int POINTS = rws_pkg::POINTS_DEFAULT
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  rws_pkg::cmd_t                  cmd,
	input  rws_pkg::item_t                 item,
	input  logic                           cfg_we,
	input  logic [rws_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rws_pkg::FRAC_W-1:0]     cfg_data,
	output rws_pkg::status_t               status,
	output rws_pkg::result_t               result
);

	localparam int AW = $clog2(POINTS);
	localparam int CW = $clog2(POINTS + 1);
	localparam int SW = CW + 2;
	localparam int FW = rws_pkg::FRAC_W;
	localparam int PW = CW + FW;
	localparam int VW = rws_pkg::VALUE_W;
	localparam int IW = rws_pkg::IDX_W;

	logic [FW-1:0] min_frac_q, max_frac_q;
	logic [FW-1:0] min_clamp, max_clamp;
	logic [CW-1:0] count_q, n_q;
	logic          full;
	logic [CW-1:0] lo_q, hi_q;
	logic [AW-1:0] i_q;
	logic [CW-1:0] j_q;
	logic          cmp_s1;
	logic [AW-1:0] jx_s1;
	logic [AW-1:0] rank_q;
	logic signed [VW-1:0] v_q;

	logic [VW-1:0] rdata;
	logic [AW-1:0] raddr;
	logic          ram_we;
	logic [PW-1:0] lo_prod, hi_prod;
	logic signed [SW-1:0] lo_w, hi_w, lim_w, span_w;
	logic signed [VW-1:0] w_val;
	logic          hit;
	logic          issue;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_frac_q <= '0;
			max_frac_q <= rws_pkg::FRAC_ONE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rws_pkg::REG_MIN_FRACTION: min_frac_q <= cfg_data;
				rws_pkg::REG_MAX_FRACTION: max_frac_q <= cfg_data;
			endcase
		end
	end

	// Fractions above one count as one
	assign min_clamp = (min_frac_q > rws_pkg::FRAC_ONE) ? rws_pkg::FRAC_ONE : min_frac_q;
	assign max_clamp = (max_frac_q > rws_pkg::FRAC_ONE) ? rws_pkg::FRAC_ONE : max_frac_q;

	// Value store
	assign full   = (count_q >= CW'(POINTS));
	assign ram_we = cmd.load && !full;
	assign raddr  = cmd.fetch ? i_q : j_q[AW-1:0];

	rws_ram #(
		.WIDTH(VW),
		.DEPTH(POINTS)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(count_q[AW-1:0]),
		.wdata(item.feature_value),
		.raddr(raddr),
		.rdata(rdata)
	);

	// Load counter and point count of the run
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			n_q     <= '0;
		end else if (cmd.finish) begin
			count_q <= '0;
			n_q     <= full ? count_q : count_q + CW'(1);
		end else if (ram_we) begin
			count_q <= count_q + CW'(1);
		end
	end

	// Window edges: floor(n * fraction)
	assign lo_prod = PW'(n_q) * PW'(min_clamp);
	assign hi_prod = PW'(n_q) * PW'(max_clamp);

	// Widen to the minimum span: raise max (cap n-1), then lower min (floor 0)
	always_comb begin
		span_w = $signed(SW'(rws_pkg::MIN_SPAN));
		lo_w   = $signed(SW'(lo_q));
		hi_w   = $signed(SW'(hi_q));
		lim_w  = $signed(SW'(n_q)) - $signed(SW'(1));
		if (hi_w - lo_w < span_w) begin
			hi_w = lo_w + span_w;
			if (hi_w > lim_w) begin
				hi_w = lim_w;
			end
			if (hi_w - lo_w < span_w) begin
				lo_w = hi_w - span_w;
				if (lo_w[SW-1]) begin
					lo_w = '0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.calc) begin
			lo_q <= lo_prod[FW-1 +: CW];
			hi_q <= hi_prod[FW-1 +: CW];
		end else if (cmd.widen) begin
			lo_q <= lo_w[CW-1:0];
			hi_q <= hi_w[CW-1:0];
		end
	end

	// Sweep control: read addresses and compare slot
	assign issue = (j_q < n_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q    <= '0;
			j_q    <= '0;
			cmp_s1 <= 1'b0;
		end else begin
			if (cmd.widen) begin
				i_q <= '0;
			end else if (cmd.emit) begin
				i_q <= i_q + AW'(1);
			end

			if (cmd.fetch) begin
				j_q    <= '0;
				cmp_s1 <= 1'b0;
			end else if (cmd.latch) begin
				j_q    <= CW'(1);
				cmp_s1 <= 1'b1;
			end else if (cmd.sweep) begin
				cmp_s1 <= issue;
				if (issue) begin
					j_q <= j_q + CW'(1);
				end
			end else begin
				cmp_s1 <= 1'b0;
			end
		end
	end

	// Compare: smaller value, or equal value at lower index
	assign w_val = $signed(rdata);
	assign hit   = (w_val < v_q) || ((w_val == v_q) && (jx_s1 < i_q));

	always_ff @(posedge clk) begin
		if (cmd.fetch) begin
			rank_q <= '0;
		end else if (cmd.sweep && cmp_s1 && hit) begin
			rank_q <= rank_q + AW'(1);
		end
		if (cmd.latch) begin
			v_q   <= $signed(rdata);
			jx_s1 <= '0;
		end else if (cmd.sweep) begin
			jx_s1 <= j_q[AW-1:0];
		end
	end

	// Status
	assign status.sweep_done = cmd.sweep && cmp_s1 && (CW'(jx_s1) == n_q - CW'(1));
	assign status.last_point = (CW'(i_q) == n_q - CW'(1));

	// Result fields
	assign result.point_index = IW'(i_q);
	assign result.point_rank  = IW'(rank_q);
	assign result.active      = (CW'(rank_q) >= lo_q) && (CW'(rank_q) < hi_q);
	assign result.last_result = status.last_point;

endmodule

>>> src/rws_ctrl.sv
`timescale 1ns / 1ps

module rws_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             last_value,
	input  rws_pkg::status_t status,
	output rws_pkg::cmd_t    cmd,
	output logic             busy,
	output logic             result_valid
);

	rws_pkg::state_t state_q, state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rws_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			rws_pkg::ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					if (last_value) begin
						cmd.finish = 1'b1;
						state_d    = rws_pkg::ST_CALC;
					end
				end
			end
			rws_pkg::ST_CALC: begin
				cmd.calc = 1'b1;
				state_d  = rws_pkg::ST_WIDEN;
			end
			rws_pkg::ST_WIDEN: begin
				cmd.widen = 1'b1;
				state_d   = rws_pkg::ST_FETCH;
			end
			rws_pkg::ST_FETCH: begin
				cmd.fetch = 1'b1;
				state_d   = rws_pkg::ST_LATCH;
			end
			rws_pkg::ST_LATCH: begin
				cmd.latch = 1'b1;
				state_d   = rws_pkg::ST_SWEEP;
			end
			rws_pkg::ST_SWEEP: begin
				cmd.sweep = 1'b1;
				if (status.sweep_done) begin
					state_d = rws_pkg::ST_EMIT;
				end
			end
			rws_pkg::ST_EMIT: begin
				cmd.emit = 1'b1;
				state_d  = status.last_point ? rws_pkg::ST_IDLE : rws_pkg::ST_FETCH;
			end
			default: begin
				state_d = rws_pkg::ST_IDLE;
			end
		endcase
	end

	assign busy         = (state_q != rws_pkg::ST_IDLE);
	assign result_valid = cmd.emit;

endmodule

>>> src/rank_window_selector.sv
`timescale 1ns / 1ps

// Rank window selector.
// Requests: item (feature value, last mark) is taken on a clock edge with
// start high and busy low. Values are stored in load order, up to POINTS of
// them; further values are dropped, but their last mark still counts.
// A request without the last mark leaves busy low.
// On the last mark the block ranks all n stored points (ascending value,
// ties to the lower index), forms the rank window from min_fraction and
// max_fraction, and emits one result per point in load order, each for one
// cycle with result_valid high; last_result marks the final one.
// Each point is ranked by one sweep over the single read port of the value
// store, through the states fetch, latch, sweep and emit; the run begins
// with the calc and widen states. busy is high from the cycle after the
// last request through the cycle of the final result.
// The receiver cannot stall: every result is taken in its cycle.
// The user writes configuration (cfg_we, cfg_index, cfg_data) only while
// busy is low; the block itself does not enforce it. Reset clears the load
// count and sets the fractions to 0 and one; the store needs no clearing.
module rank_window_selector #(
	parameter int POINTS = rws_pkg::POINTS_DEFAULT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  rws_pkg::item_t                item,
	output logic                          result_valid,
	output rws_pkg::result_t              result,
	input  logic                          cfg_we,
	input  logic [rws_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rws_pkg::FRAC_W-1:0]    cfg_data
);

	rws_pkg::cmd_t    cmd;
	rws_pkg::status_t status;

	rws_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.last_value  (item.last_value),
		.status      (status),
		.cmd         (cmd),
		.busy        (busy),
		.result_valid(result_valid)
	);

	rws_datapath #(
		.POINTS(POINTS)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.item     (item),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.status   (status),
		.result   (result)
	);

endmodule
